// ===== hw/rtl/dbgid_pkg.sv =====
// Shared constants and types for the double-byte glyph index decoder.
package dbgid_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OffsetW = 19;
  localparam int unsigned RowW    = 7;
  localparam int unsigned IdxW    = 14;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_NONE = 2'd0,
    KIND_HALF = 2'd1,
    KIND_FULL = 2'd2,
    KIND_BAD  = 2'd3
  } glyph_kind_t;

  // Text modes
  typedef enum logic [ModeW-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_SJIS   = 2'd1,
    MODE_EUC    = 2'd2,
    MODE_UNUSED = 2'd3
  } text_mode_t;

  // Register word index
  localparam logic REG_TEXT_MODE = 1'b0;

  // Code ranges
  localparam logic [ByteW-1:0] SjisLead1Lo = 8'h81;
  localparam logic [ByteW-1:0] SjisLead1Hi = 8'h9f;
  localparam logic [ByteW-1:0] SjisLead2Lo = 8'he0;
  localparam logic [ByteW-1:0] SjisLead2Hi = 8'hfc;
  localparam logic [ByteW-1:0] SjisTrl1Lo  = 8'h40;
  localparam logic [ByteW-1:0] SjisTrl1Hi  = 8'h7e;
  localparam logic [ByteW-1:0] SjisTrl2Lo  = 8'h80;
  localparam logic [ByteW-1:0] SjisTrl2Hi  = 8'h9e;
  localparam logic [ByteW-1:0] SjisTrl3Lo  = 8'h9f;
  localparam logic [ByteW-1:0] EucLeadLo   = 8'h81;
  localparam logic [ByteW-1:0] EucLo       = 8'ha1;
  localparam logic [ByteW-1:0] EucHi       = 8'hfe;
  localparam logic [RowW-1:0]  SjisRowBase2 = 7'd62;
  localparam logic [ByteW-1:0] SjisCellAdj2 = 8'd63;
  localparam logic [IdxW-1:0]  CellsPerRow  = 14'd94;
  localparam logic [OffsetW-1:0] FullBase   = 19'd4096;

endpackage

// ===== hw/rtl/double_byte_glyph_index_decoder.sv =====
// Top level: byte stream to font store glyph offset (single-byte, Shift-JIS, EUC-JP).
//
// Usage:
//  - Input channel (in_valid/in_ready/in_code_byte) takes one text byte per transfer.
//  - Result channel (out_valid/out_ready/out_glyph_kind/out_glyph_offset) gives exactly
//    one result per input byte, in order. A lead byte answers "nothing drawn"; its trail
//    byte answers the full-width glyph offset (or an invalid pair).
//  - Configuration: APB-style port, text_mode at byte address 0 (0 single-byte,
//    1 Shift-JIS, 2 EUC-JP). Change it only while the block is idle.
//  - Path: an accepted byte is registered in the input register, then decoded into the
//    output register, and is visible on the result channel from that register.
//  - Throughput: one byte per cycle while out_ready is high, set by the single decode stage
//    between the input and output registers; the held lead byte updates in the same stage.
//  - Stall: when out_ready is low the result stays put, the decode stage holds one more
//    byte, and in_ready drops once both are full. No transfer is lost or repeated.
//  - Reset (rst_n low, synchronous): both stages empty, no lead byte held, text_mode 0.
module double_byte_glyph_index_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dbgid_pkg::ByteW-1:0]     in_code_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dbgid_pkg::KindW-1:0]     out_glyph_kind,
  output logic [dbgid_pkg::OffsetW-1:0]   out_glyph_offset,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dbgid_pkg::AddrW-1:0]     cfg_paddr,
  input  logic [dbgid_pkg::DataW-1:0]     cfg_pwdata,
  output logic [dbgid_pkg::DataW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import dbgid_pkg::*;

  // Registers
  text_mode_t            text_mode_r;
  logic                  s1_valid_r;
  logic [ByteW-1:0]      s1_byte_r;
  logic [ByteW-1:0]      lead_r, lead_nxt;
  logic                  out_valid_r;
  glyph_kind_t           kind_r, kind_nxt;
  logic [OffsetW-1:0]    offset_r, offset_nxt;

  logic                  out_free;
  logic                  s1_go;
  logic                  reg_sel;

  // Handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_go;

  assign out_valid        = out_valid_r;
  assign out_glyph_kind   = kind_r;
  assign out_glyph_offset = offset_r;

  // Configuration port
  assign reg_sel    = (cfg_paddr[AddrW-1] == REG_TEXT_MODE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {{(DataW-ModeW){1'b0}}, text_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_mode_r <= MODE_SINGLE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      text_mode_r <= text_mode_t'(cfg_pwdata[ModeW-1:0]);
    end
  end

  // Decode stage
  always_comb begin
    logic [ByteW-1:0]   b;
    logic               b_sjis_lead;
    logic               l_sjis_lead;
    logic [ByteW-1:0]   lead_off;
    logic [RowW-1:0]    row;
    logic [ByteW-1:0]   cell_idx;
    logic               pair_ok;
    logic [IdxW-1:0]    idx;
    logic [OffsetW-1:0] full_off;
    logic [OffsetW-1:0] half_off;

    b           = s1_byte_r;
    b_sjis_lead = (b >= SjisLead1Lo && b <= SjisLead1Hi) ||
                  (b >= SjisLead2Lo && b <= SjisLead2Hi);
    l_sjis_lead = (lead_r >= SjisLead1Lo && lead_r <= SjisLead1Hi) ||
                  (lead_r >= SjisLead2Lo && lead_r <= SjisLead2Hi);
    half_off    = {{(OffsetW-ByteW-4){1'b0}}, b, 4'b0000};
    row         = '0;
    cell_idx    = '0;
    pair_ok     = 1'b0;

    // Row and cell of a held pair
    if (text_mode_r == MODE_SJIS) begin
      if (lead_r <= SjisLead1Hi) begin
        lead_off = lead_r - SjisLead1Lo;
        row      = {lead_off[RowW-2:0], 1'b0};
      end else begin
        lead_off = lead_r - SjisLead2Lo;
        row      = {lead_off[RowW-2:0], 1'b0} + SjisRowBase2;
      end
      if (b >= SjisTrl1Lo && b <= SjisTrl1Hi) begin
        cell_idx = b - SjisTrl1Lo;
        pair_ok  = l_sjis_lead;
      end else if (b >= SjisTrl2Lo && b <= SjisTrl2Hi) begin
        cell_idx = b - SjisTrl2Lo + SjisCellAdj2;
        pair_ok  = l_sjis_lead;
      end else if (b >= SjisTrl3Lo && b <= SjisLead2Hi) begin
        cell_idx = b - SjisTrl3Lo;
        row      = row + 7'd1;
        pair_ok  = l_sjis_lead;
      end
    end else begin
      lead_off = lead_r - EucLo;
      row      = lead_off[RowW-1:0];
      cell_idx = b - EucLo;
      pair_ok  = (lead_r >= EucLo) && (lead_r <= EucHi) && (b >= EucLo) && (b <= EucHi);
    end

    idx      = IdxW'(row) * CellsPerRow + IdxW'(cell_idx);
    full_off = FullBase + {idx, 5'b00000};

    // Result selection and lead update
    lead_nxt   = lead_r;
    kind_nxt   = KIND_NONE;
    offset_nxt = '0;
    if (b != '0) begin
      case (text_mode_r)
        MODE_SINGLE: begin
          kind_nxt   = KIND_HALF;
          offset_nxt = half_off;
        end
        MODE_SJIS, MODE_EUC: begin
          if (lead_r == '0) begin
            if ((text_mode_r == MODE_SJIS && b_sjis_lead) ||
                (text_mode_r == MODE_EUC && b >= EucLeadLo && b <= EucHi)) begin
              lead_nxt = b;
            end else begin
              kind_nxt   = KIND_HALF;
              offset_nxt = half_off;
            end
          end else begin
            lead_nxt = '0;
            if (pair_ok) begin
              kind_nxt   = KIND_FULL;
              offset_nxt = full_off;
            end else begin
              kind_nxt = KIND_BAD;
            end
          end
        end
        default: begin
          kind_nxt = KIND_NONE;
        end
      endcase
    end
  end

  // Input register and held lead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      lead_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        lead_r <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_code_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule
